FILE: hdl/glzw_pkg.sv
package glzw_pkg;

    localparam int DICT_ENTRIES  = 4096;
    localparam int MAX_CODE_BITS = 12;
    localparam int DICT_LIMIT    = (DICT_ENTRIES < (1 << MAX_CODE_BITS)) ?
                                   DICT_ENTRIES : (1 << MAX_CODE_BITS);
    localparam int ADDR_W        = $clog2(DICT_ENTRIES);
    localparam int NEXT_W        = ADDR_W + 1;
    localparam int CODE_W        = 12;
    localparam int BUF_W         = 20;
    localparam int CNT_W         = 5;
    localparam int ROOT_RESET    = 8;
    localparam int LIMIT_RESET   = 16384;

    localparam logic [1:0] FN_START = 2'd0;
    localparam logic [1:0] FN_FEED  = 2'd1;
    localparam logic [1:0] FN_FETCH = 2'd2;
    localparam logic [1:0] FN_NONE  = 2'd3;

    localparam logic [2:0] ST_PIXEL = 3'd0;
    localparam logic [2:0] ST_NEED  = 3'd1;
    localparam logic [2:0] ST_END   = 3'd2;
    localparam logic [2:0] ST_OVER  = 3'd3;
    localparam logic [2:0] ST_BAD   = 3'd4;
    localparam logic [2:0] ST_OK    = 3'd5;

    localparam logic CFG_ROOT_BITS   = 1'b0;
    localparam logic CFG_PIXEL_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_START,
        OP_FEED,
        OP_POP,
        OP_CLEAR,
        OP_END,
        OP_ROOT,
        OP_DECODE,
        OP_WALK,
        OP_WALK_END,
        OP_KW_FIX,
        OP_LOAD_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] status;
    } cmd_t;

    typedef struct packed {
        logic ended;
        logic stack_nonempty;
        logic at_limit;
        logic bits_short;
        logic code_clear;
        logic code_end;
        logic after_clear;
        logic code_above_roots;
        logic code_bad;
        logic feed_full;
        logic walk_start;
        logic walk_more;
        logic kw_pending;
        logic out_free;
    } flags_t;

endpackage

FILE: hdl/glzw_dpath.sv
module glzw_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  glzw_pkg::cmd_t      cmd,
    output glzw_pkg::flags_t    flags,
    input  logic [7:0]          data_byte,
    input  logic                cfg_wen,
    input  logic                cfg_index,
    input  logic [16:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          pixel,
    output logic [2:0]          status
);

    localparam int AW = glzw_pkg::ADDR_W;
    localparam int NW = glzw_pkg::NEXT_W;
    localparam int CW = glzw_pkg::CODE_W;
    localparam int BW = glzw_pkg::BUF_W;
    localparam int KW = glzw_pkg::CNT_W;

    logic [3:0]     root_bits_reg,   root_bits_next;
    logic [16:0]    pixel_limit_reg, pixel_limit_next;
    logic [BW-1:0]  bit_buffer_reg,  bit_buffer_next;
    logic [KW-1:0]  bit_count_reg,   bit_count_next;
    logic [NW-1:0]  stack_depth_reg, stack_depth_next;
    logic [3:0]     code_width_reg,  code_width_next;
    logic [NW-1:0]  next_entry_reg,  next_entry_next;
    logic [CW-1:0]  prev_code_reg,   prev_code_next;
    logic           after_clear_reg, after_clear_next;
    logic [16:0]    pixel_count_reg, pixel_count_next;
    logic           ended_reg,       ended_next;
    logic [CW-1:0]  walk_code_reg,   walk_code_next;
    logic [AW-1:0]  walk_guard_reg,  walk_guard_next;
    logic [CW-1:0]  cur_code_reg,    cur_code_next;
    logic           kw_reg,          kw_next;
    logic [AW-1:0]  kw_slot_reg,     kw_slot_next;
    logic [7:0]     first_reg,       first_next;
    logic           out_valid_reg,   out_valid_next;
    logic [7:0]     pixel_reg,       pixel_next;
    logic [2:0]     status_reg,      status_next;

    logic [CW-1:0]  prefix_mem [glzw_pkg::DICT_ENTRIES];
    logic [7:0]     suffix_mem [glzw_pkg::DICT_ENTRIES];
    logic [7:0]     stack_mem  [glzw_pkg::DICT_ENTRIES];
    logic [CW-1:0]  prefix_q;
    logic [7:0]     suffix_q;
    logic [7:0]     stack_q;

    logic           dict_we, dict_re;
    logic [AW-1:0]  dict_raddr;
    logic           stk_we, stk_re;
    logic [AW-1:0]  stk_waddr, stk_raddr;
    logic [7:0]     stk_wdata;

    logic [3:0]     eff_root;
    logic [NW-1:0]  roots;
    logic [3:0]     w_eff;
    logic [CW-1:0]  mask;
    logic [CW-1:0]  code;
    logic [NW-1:0]  code_x;
    logic           code_kw;
    logic [CW-1:0]  c_sel;
    logic [BW-1:0]  buf_consumed;
    logic [KW-1:0]  cnt_consumed;
    logic           can_push;
    logic [NW-1:0]  next_inc;

    always_comb
    begin
        if (root_bits_reg < 4'd2)
            eff_root = 4'd2;
        else if (root_bits_reg > 4'd8)
            eff_root = 4'd8;
        else
            eff_root = root_bits_reg;
    end

    assign roots = NW'(1) << eff_root;
    assign w_eff = (code_width_reg == 4'd0 || code_width_reg > 4'(glzw_pkg::MAX_CODE_BITS)) ?
                   4'(glzw_pkg::MAX_CODE_BITS) : code_width_reg;
    assign mask  = CW'((NW'(1) << w_eff) - NW'(1));
    assign code  = bit_buffer_reg[CW-1:0] & mask;
    assign code_x = {1'b0, code};
    assign code_kw = (code_x == next_entry_reg);
    assign c_sel = code_kw ? prev_code_reg : code;
    assign buf_consumed = bit_buffer_reg >> w_eff;
    assign cnt_consumed = bit_count_reg - KW'(w_eff);
    assign can_push = (stack_depth_reg < NW'(glzw_pkg::DICT_ENTRIES));
    assign next_inc = next_entry_reg + NW'(1);

    always_comb
    begin
        flags.ended            = ended_reg;
        flags.stack_nonempty   = (stack_depth_reg != '0);
        flags.at_limit         = (pixel_count_reg >= pixel_limit_reg);
        flags.bits_short       = (bit_count_reg < KW'(w_eff));
        flags.code_clear       = (code_x == roots);
        flags.code_end         = (code_x == roots + NW'(1));
        flags.after_clear      = after_clear_reg;
        flags.code_above_roots = (code_x > roots);
        flags.code_bad         = (code_x > next_entry_reg) ||
                                 (code_kw && next_entry_reg >= NW'(glzw_pkg::DICT_LIMIT));
        flags.feed_full        = (bit_count_reg > KW'(12));
        flags.walk_start       = ({1'b0, c_sel} >= roots) &&
                                 ({1'b0, c_sel} < NW'(glzw_pkg::DICT_ENTRIES));
        flags.walk_more        = ({1'b0, prefix_q} >= roots) &&
                                 ({1'b0, prefix_q} < NW'(glzw_pkg::DICT_ENTRIES)) &&
                                 (walk_guard_reg != '1);
        flags.kw_pending       = kw_reg;
        flags.out_free         = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        root_bits_next   = root_bits_reg;
        pixel_limit_next = pixel_limit_reg;
        bit_buffer_next  = bit_buffer_reg;
        bit_count_next   = bit_count_reg;
        stack_depth_next = stack_depth_reg;
        code_width_next  = code_width_reg;
        next_entry_next  = next_entry_reg;
        prev_code_next   = prev_code_reg;
        after_clear_next = after_clear_reg;
        pixel_count_next = pixel_count_reg;
        ended_next       = ended_reg;
        walk_code_next   = walk_code_reg;
        walk_guard_next  = walk_guard_reg;
        cur_code_next    = cur_code_reg;
        kw_next          = kw_reg;
        kw_slot_next     = kw_slot_reg;
        first_next       = first_reg;
        out_valid_next   = out_valid_reg && out_stall;
        pixel_next       = pixel_reg;
        status_next      = status_reg;
        dict_we          = 1'b0;
        dict_re          = 1'b0;
        dict_raddr       = prefix_q[AW-1:0];
        stk_we           = 1'b0;
        stk_re           = 1'b0;
        stk_waddr        = stack_depth_reg[AW-1:0];
        stk_raddr        = AW'(stack_depth_reg - NW'(1));
        stk_wdata        = suffix_q;

        if (cfg_wen)
        begin
            if (cfg_index == glzw_pkg::CFG_ROOT_BITS)
                root_bits_next = cfg_data[3:0];
            else
                pixel_limit_next = cfg_data;
        end

        case (cmd.op)
            glzw_pkg::OP_START:
            begin
                bit_buffer_next  = '0;
                bit_count_next   = '0;
                stack_depth_next = '0;
                prev_code_next   = '0;
                pixel_count_next = '0;
                ended_next       = 1'b0;
                code_width_next  = eff_root + 4'd1;
                next_entry_next  = roots + NW'(2);
                after_clear_next = 1'b1;
            end
            glzw_pkg::OP_FEED:
            begin
                bit_buffer_next = bit_buffer_reg | (BW'(data_byte) << bit_count_reg);
                bit_count_next  = bit_count_reg + KW'(8);
            end
            glzw_pkg::OP_POP:
            begin
                stk_re           = 1'b1;
                stack_depth_next = stack_depth_reg - NW'(1);
                pixel_count_next = pixel_count_reg + 17'd1;
            end
            glzw_pkg::OP_CLEAR:
            begin
                bit_buffer_next  = buf_consumed;
                bit_count_next   = cnt_consumed;
                code_width_next  = eff_root + 4'd1;
                next_entry_next  = roots + NW'(2);
                after_clear_next = 1'b1;
            end
            glzw_pkg::OP_END:
            begin
                bit_buffer_next = buf_consumed;
                bit_count_next  = cnt_consumed;
                ended_next      = 1'b1;
            end
            glzw_pkg::OP_ROOT:
            begin
                bit_buffer_next  = buf_consumed;
                bit_count_next   = cnt_consumed;
                stk_wdata        = code[7:0];
                if (can_push)
                begin
                    stk_we           = 1'b1;
                    stack_depth_next = stack_depth_reg + NW'(1);
                end
                prev_code_next   = code;
                after_clear_next = 1'b0;
            end
            glzw_pkg::OP_DECODE:
            begin
                bit_buffer_next = buf_consumed;
                bit_count_next  = cnt_consumed;
                dict_re         = 1'b1;
                dict_raddr      = c_sel[AW-1:0];
                walk_code_next  = c_sel;
                walk_guard_next = '0;
                cur_code_next   = code;
                kw_slot_next    = stack_depth_reg[AW-1:0];
                // KwKwK: keep a slot for the new entry's suffix, known only at chain end
                kw_next         = code_kw && can_push;
                if (code_kw && can_push)
                    stack_depth_next = stack_depth_reg + NW'(1);
            end
            glzw_pkg::OP_WALK:
            begin
                dict_re         = 1'b1;
                dict_raddr      = prefix_q[AW-1:0];
                stk_wdata       = suffix_q;
                if (can_push)
                begin
                    stk_we           = 1'b1;
                    stack_depth_next = stack_depth_reg + NW'(1);
                end
                walk_code_next  = prefix_q;
                walk_guard_next = walk_guard_reg + AW'(1);
            end
            glzw_pkg::OP_WALK_END:
            begin
                stk_wdata  = walk_code_reg[7:0];
                if (can_push)
                begin
                    stk_we           = 1'b1;
                    stack_depth_next = stack_depth_reg + NW'(1);
                end
                first_next = walk_code_reg[7:0];
                if (next_entry_reg < NW'(glzw_pkg::DICT_LIMIT))
                begin
                    dict_we         = 1'b1;
                    next_entry_next = next_inc;
                    if (next_inc == (NW'(1) << w_eff) &&
                        w_eff < 4'(glzw_pkg::MAX_CODE_BITS) &&
                        next_inc < NW'(glzw_pkg::DICT_LIMIT))
                        code_width_next = w_eff + 4'd1;
                end
                prev_code_next = cur_code_reg;
            end
            glzw_pkg::OP_KW_FIX:
            begin
                stk_we    = 1'b1;
                stk_waddr = kw_slot_reg;
                stk_wdata = first_reg;
                kw_next   = 1'b0;
            end
            glzw_pkg::OP_LOAD_OUT:
            begin
                out_valid_next = 1'b1;
                status_next    = cmd.status;
                pixel_next     = (cmd.status == glzw_pkg::ST_PIXEL) ? stack_q : 8'd0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dict_we)
        begin
            prefix_mem[next_entry_reg[AW-1:0]] <= prev_code_reg;
            suffix_mem[next_entry_reg[AW-1:0]] <= walk_code_reg[7:0];
        end
        if (dict_re)
        begin
            prefix_q <= prefix_mem[dict_raddr];
            suffix_q <= suffix_mem[dict_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[stk_waddr] <= stk_wdata;
        if (stk_re)
            stack_q <= stack_mem[stk_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_bits_reg   <= 4'(glzw_pkg::ROOT_RESET);
            pixel_limit_reg <= 17'(glzw_pkg::LIMIT_RESET);
            bit_buffer_reg  <= '0;
            bit_count_reg   <= '0;
            stack_depth_reg <= '0;
            code_width_reg  <= 4'(glzw_pkg::ROOT_RESET + 1);
            next_entry_reg  <= NW'((1 << glzw_pkg::ROOT_RESET) + 2);
            prev_code_reg   <= '0;
            after_clear_reg <= 1'b1;
            pixel_count_reg <= '0;
            ended_reg       <= 1'b0;
            walk_guard_reg  <= '0;
            kw_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            root_bits_reg   <= root_bits_next;
            pixel_limit_reg <= pixel_limit_next;
            bit_buffer_reg  <= bit_buffer_next;
            bit_count_reg   <= bit_count_next;
            stack_depth_reg <= stack_depth_next;
            code_width_reg  <= code_width_next;
            next_entry_reg  <= next_entry_next;
            prev_code_reg   <= prev_code_next;
            after_clear_reg <= after_clear_next;
            pixel_count_reg <= pixel_count_next;
            ended_reg       <= ended_next;
            walk_guard_reg  <= walk_guard_next;
            kw_reg          <= kw_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_code_reg <= walk_code_next;
        cur_code_reg  <= cur_code_next;
        kw_slot_reg   <= kw_slot_next;
        first_reg     <= first_next;
        pixel_reg     <= pixel_next;
        status_reg    <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign pixel     = pixel_reg;
    assign status    = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= KW'(BW))
        else $error("bit count beyond buffer width");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == glzw_pkg::OP_POP |-> stack_depth_reg != '0)
        else $error("pop from empty pixel stack");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == glzw_pkg::OP_LOAD_OUT |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a waiting item");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stack_depth_reg <= NW'(glzw_pkg::DICT_ENTRIES))
        else $error("pixel stack depth out of range");

endmodule

FILE: hdl/glzw_ctrl.sv
module glzw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          func,
    input  glzw_pkg::flags_t    flags,
    output glzw_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_WALK,
        S_WALK_END,
        S_KW,
        S_REPLY
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] reply_reg, reply_next;

    always_comb
    begin
        state_next = state_reg;
        reply_next = reply_reg;
        cmd.op     = glzw_pkg::OP_IDLE;
        cmd.status = reply_reg;
        in_stall   = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (func)
                        glzw_pkg::FN_START:
                        begin
                            cmd.op     = glzw_pkg::OP_START;
                            reply_next = glzw_pkg::ST_OK;
                            state_next = S_REPLY;
                        end
                        glzw_pkg::FN_FEED:
                        begin
                            if (flags.feed_full)
                                reply_next = glzw_pkg::ST_OVER;
                            else
                            begin
                                cmd.op     = glzw_pkg::OP_FEED;
                                reply_next = glzw_pkg::ST_OK;
                            end
                            state_next = S_REPLY;
                        end
                        glzw_pkg::FN_FETCH:
                            state_next = S_FETCH;
                        default:
                        begin
                            reply_next = glzw_pkg::ST_BAD;
                            state_next = S_REPLY;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                if (flags.ended)
                begin
                    reply_next = glzw_pkg::ST_END;
                    state_next = S_REPLY;
                end
                else if (flags.stack_nonempty)
                begin
                    if (flags.at_limit)
                        reply_next = glzw_pkg::ST_OVER;
                    else
                    begin
                        cmd.op     = glzw_pkg::OP_POP;
                        reply_next = glzw_pkg::ST_PIXEL;
                    end
                    state_next = S_REPLY;
                end
                else if (flags.bits_short)
                begin
                    reply_next = glzw_pkg::ST_NEED;
                    state_next = S_REPLY;
                end
                else if (flags.code_clear)
                    cmd.op = glzw_pkg::OP_CLEAR;
                else if (flags.code_end)
                begin
                    cmd.op     = glzw_pkg::OP_END;
                    reply_next = glzw_pkg::ST_END;
                    state_next = S_REPLY;
                end
                else if (flags.after_clear)
                begin
                    if (flags.code_above_roots)
                    begin
                        reply_next = glzw_pkg::ST_BAD;
                        state_next = S_REPLY;
                    end
                    else
                        cmd.op = glzw_pkg::OP_ROOT;
                end
                else if (flags.code_bad)
                begin
                    reply_next = glzw_pkg::ST_BAD;
                    state_next = S_REPLY;
                end
                else
                begin
                    cmd.op     = glzw_pkg::OP_DECODE;
                    state_next = flags.walk_start ? S_WALK : S_WALK_END;
                end
            end
            S_WALK:
            begin
                cmd.op = glzw_pkg::OP_WALK;
                if (!flags.walk_more)
                    state_next = S_WALK_END;
            end
            S_WALK_END:
            begin
                cmd.op     = glzw_pkg::OP_WALK_END;
                state_next = flags.kw_pending ? S_KW : S_FETCH;
            end
            S_KW:
            begin
                cmd.op     = glzw_pkg::OP_KW_FIX;
                state_next = S_FETCH;
            end
            S_REPLY:
            begin
                if (flags.out_free)
                begin
                    cmd.op     = glzw_pkg::OP_LOAD_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            reply_reg <= glzw_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end

endmodule

FILE: hdl/gif_lzw_decoder_unit.sv
// GIF LZW decoder, one result item per input item. Start and feed items go from
// acceptance to the reply state, which loads the result into the output register once
// that register is free; a fetch that pops a waiting pixel reads it from the pixel
// stack on its way to the reply state. A fetch that must decode a new code walks the
// prefix chain one dictionary entry per cycle through the registered-read
// prefix/suffix memories onto the pixel stack and then pops (in the KwKwK case the
// string's last pixel is filled in after the walk); each clear code adds a pass
// through the fetch state. Input stall is high from acceptance until the result is
// loaded into the output register; the next item may be accepted while that result
// still waits. No clearing pass is needed after reset.
module gif_lzw_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pixel,
    output logic [2:0]  status,
    input  logic        cfg_wen,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);

    glzw_pkg::cmd_t   cmd;
    glzw_pkg::flags_t flags;

    glzw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .flags    (flags),
        .cmd      (cmd)
    );

    glzw_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .flags     (flags),
        .data_byte (data_byte),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel     (pixel),
        .status    (status)
    );

endmodule
